// ===== design/complex_fir_filter_assert.svh =====
// Assertion macros used by the complex FIR filter controller.
`ifndef COMPLEX_FIR_FILTER_ASSERT_SVH
`define COMPLEX_FIR_FILTER_ASSERT_SVH

`ifndef SYNTH
// Property checked on every rising clock edge outside of reset.
`define CFIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true outside of reset.
`define CFIR_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define CFIR_ASSERT(lbl, prop, msg)
`define CFIR_NEVER(lbl, expr, msg)
`endif

`endif

// ===== design/cfir_pkg.sv =====
// Shared constants, codes and types of the complex FIR filter.
`default_nettype none
package cfir_pkg;
	// Sizes of the filter.
	localparam int TAPS = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int IN_SAMPLE_BITS = 16;
	localparam int COEF_BITS = 16;
	localparam int OUT_BITS = 39;
	localparam int CMD_BITS = 2;
	localparam int TAP_IDX_BITS = 6;
	localparam int TAPS_CFG_BITS = 7;
	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int CELL_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

	// Count value at which the sum of the chain is complete after a sample word.
	localparam int CNT_LAST = TAPS + 1;
	localparam int CNT_W = $clog2(CNT_LAST + 1);

	localparam logic [TAPS_CFG_BITS-1:0] TAPS_RESET = TAPS_CFG_BITS'(16);

	// Command codes.
	typedef logic [CMD_BITS-1:0] cmd_t;
	localparam cmd_t CMD_COEF = 2'd0;
	localparam cmd_t CMD_CLEAR = 2'd1;
	localparam cmd_t CMD_SAMPLE = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	// Control broadcast from the controller to every tap.
	typedef struct packed {
		logic shift;
		logic clear;
		logic coef_we;
		logic [TAP_IDX_BITS-1:0] coef_idx;
		logic [TAPS_CFG_BITS-1:0] taps_n;
	} cell_ctrl_t;
endpackage
`default_nettype wire

// ===== design/cfir_intf.sv =====
// Channel interfaces of the complex FIR filter: input words, results, configuration.
`default_nettype none
interface cfir_sample_if import cfir_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_BITS-1:0] cmd;
	logic [TAP_IDX_BITS-1:0] tap_index;
	logic signed [COEF_BITS-1:0] coef_real;
	logic signed [COEF_BITS-1:0] coef_imag;
	logic signed [IN_SAMPLE_BITS-1:0] sample_real;
	logic signed [IN_SAMPLE_BITS-1:0] sample_imag;
	logic last_sample;

	modport source(output valid, cmd, tap_index, coef_real, coef_imag, sample_real,
		sample_imag, last_sample, input ready);
	modport sink(input valid, cmd, tap_index, coef_real, coef_imag, sample_real,
		sample_imag, last_sample, output ready);
endinterface

interface cfir_result_if import cfir_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [OUT_BITS-1:0] out_real;
	logic signed [OUT_BITS-1:0] out_imag;
	logic batch_end;

	modport source(output valid, out_real, out_imag, batch_end, input ready);
	modport sink(input valid, out_real, out_imag, batch_end, output ready);
endinterface

interface cfir_cfg_if import cfir_pkg::*; ();
	logic valid;
	logic ready;
	logic [TAPS_CFG_BITS-1:0] taps_in_use;

	modport source(output valid, taps_in_use, input ready);
	modport sink(input valid, taps_in_use, output ready);
endinterface
`default_nettype wire

// ===== design/cfir_cell.sv =====
// One partial-sum stage of the chain: adds one tap term and hands the sum on.
`default_nettype none
module cfir_cell import cfir_pkg::*; (
	input logic clk,
	input logic tap_en,
	input logic signed [PROD_W:0] term,
	input logic [OUT_BITS-1:0] psum_in,
	output logic [OUT_BITS-1:0] psum_out
);
	logic [OUT_BITS-1:0] psum_q;

	// Partial sum handed on to the next position; wraps at the output width.
	always_ff @(posedge clk) begin
		psum_q <= psum_in + (tap_en ? OUT_BITS'(term) : '0);
	end

	assign psum_out = psum_q;
endmodule
`default_nettype wire

// ===== design/cfir_cell_pair.sv =====
// Real and imaginary taps of one position, sharing delay line and coefficient.
`default_nettype none
module cfir_cell_pair import cfir_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [CELL_IDX_W-1:0] tap_pos,
	input cell_ctrl_t ctrl,
	input logic signed [SAMPLE_BITS-1:0] hist_real_in,
	input logic signed [SAMPLE_BITS-1:0] hist_imag_in,
	input logic signed [COEF_BITS-1:0] coef_real_in,
	input logic signed [COEF_BITS-1:0] coef_imag_in,
	input logic [OUT_BITS-1:0] psum_real_in,
	input logic [OUT_BITS-1:0] psum_imag_in,
	output logic signed [SAMPLE_BITS-1:0] hist_real_out,
	output logic signed [SAMPLE_BITS-1:0] hist_imag_out,
	output logic [OUT_BITS-1:0] psum_real_out,
	output logic [OUT_BITS-1:0] psum_imag_out
);
	logic signed [SAMPLE_BITS-1:0] hist_real_q;
	logic signed [SAMPLE_BITS-1:0] hist_imag_q;
	logic signed [COEF_BITS-1:0] coef_real_q;
	logic signed [COEF_BITS-1:0] coef_imag_q;
	logic signed [PROD_W-1:0] m_rr_q;
	logic signed [PROD_W-1:0] m_ii_q;
	logic signed [PROD_W-1:0] m_ri_q;
	logic signed [PROD_W-1:0] m_ir_q;
	logic signed [PROD_W:0] term_real;
	logic signed [PROD_W:0] term_imag;
	logic coef_hit;
	logic tap_en;

	// Coefficient writes aimed at this position; taps past the count add zero.
	assign coef_hit = (TAPS_CFG_BITS'(ctrl.coef_idx) == TAPS_CFG_BITS'(tap_pos));
	assign tap_en = (TAPS_CFG_BITS'(tap_pos) < ctrl.taps_n);

	// Delay-line entry and coefficient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_real_q <= '0;
			hist_imag_q <= '0;
			coef_real_q <= '0;
			coef_imag_q <= '0;
		end else begin
			if (ctrl.clear) begin
				hist_real_q <= '0;
				hist_imag_q <= '0;
			end else if (ctrl.shift) begin
				hist_real_q <= hist_real_in;
				hist_imag_q <= hist_imag_in;
			end
			if (ctrl.coef_we && coef_hit) begin
				coef_real_q <= coef_real_in;
				coef_imag_q <= coef_imag_in;
			end
		end
	end

	// The four partial products of the complex multiply.
	always_ff @(posedge clk) begin
		m_rr_q <= hist_real_q * coef_real_q;
		m_ii_q <= hist_imag_q * coef_imag_q;
		m_ri_q <= hist_real_q * coef_imag_q;
		m_ir_q <= coef_real_q * hist_imag_q;
	end

	assign term_real = (PROD_W+1)'(m_rr_q) - (PROD_W+1)'(m_ii_q);
	assign term_imag = (PROD_W+1)'(m_ri_q) + (PROD_W+1)'(m_ir_q);

	// Partial sums handed on to the next position, one stage for each part.
	cfir_cell u_real (
		.clk(clk),
		.tap_en(tap_en),
		.term(term_real),
		.psum_in(psum_real_in),
		.psum_out(psum_real_out)
	);

	cfir_cell u_imag (
		.clk(clk),
		.tap_en(tap_en),
		.term(term_imag),
		.psum_in(psum_imag_in),
		.psum_out(psum_imag_out)
	);

	assign hist_real_out = hist_real_q;
	assign hist_imag_out = hist_imag_q;
endmodule
`default_nettype wire

// ===== design/cfir_ctrl.sv =====
// Controller: input handshake, tap count register, sequencing and result register.
`default_nettype none
`include "complex_fir_filter_assert.svh"
module cfir_ctrl import cfir_pkg::*; (
	input logic clk,
	input logic arst_n,
	cfir_sample_if.sink sample_ch,
	cfir_result_if.source result_ch,
	cfir_cfg_if.sink cfg,
	input logic [OUT_BITS-1:0] chain_real,
	input logic [OUT_BITS-1:0] chain_imag,
	output cell_ctrl_t ctrl
);
	state_t state_q;
	state_t state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [TAPS_CFG_BITS-1:0] taps_q;
	logic last_q;
	logic out_valid_q;
	logic [OUT_BITS-1:0] out_real_q;
	logic [OUT_BITS-1:0] out_imag_q;
	logic out_batch_end_q;
	logic accept;
	logic start;
	logic done;
	logic load;

	assign accept = sample_ch.valid && sample_ch.ready;
	assign start = accept && (sample_ch.cmd == CMD_SAMPLE);
	assign done = (state_q == ST_BUSY) && (cnt_q == CNT_W'(CNT_LAST));
	assign load = done && (!out_valid_q || result_ch.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and chain control.
	always_comb begin
		sample_ch.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
		ctrl.shift = start;
		ctrl.clear = accept && (sample_ch.cmd == CMD_CLEAR);
		ctrl.coef_we = accept && (sample_ch.cmd == CMD_COEF);
		ctrl.coef_idx = sample_ch.tap_index;
		ctrl.taps_n = taps_q;
	end

	// State, cycle count and tap count; the batch marker is kept below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			taps_q <= TAPS_RESET;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q <= '0;
			end else if ((state_q == ST_BUSY) && !done) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cfg.valid && cfg.ready) begin
				taps_q <= cfg.taps_in_use;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			last_q <= sample_ch.last_sample;
		end
	end

	// Result register: a finished sum waits here until the sink takes the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_real_q <= chain_real;
			out_imag_q <= chain_imag;
			out_batch_end_q <= last_q;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.out_real = out_real_q;
	assign result_ch.out_imag = out_imag_q;
	assign result_ch.batch_end = out_batch_end_q;

	// A sample word always starts a fresh count.
	`CFIR_ASSERT(a_start_count, start |=> (state_q == ST_BUSY) && (cnt_q == '0), "sample did not start the sum")
	// The count steps by one until the chain sum is complete.
	`CFIR_ASSERT(a_count_step, ((state_q == ST_BUSY) && !done) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "count skipped")
	// A result appears only at the end of a sum.
	`CFIR_ASSERT(a_result_origin, $rose(out_valid_q) |-> ($past(state_q) == ST_BUSY), "result without sum")
	// The delay line and coefficients are frozen while a sum runs.
	`CFIR_NEVER(a_frozen, (state_q == ST_BUSY) && (ctrl.clear || ctrl.coef_we || ctrl.shift), "state changed during sum")
endmodule
`default_nettype wire

// ===== design/complex_fir_filter.sv =====
// Top level of the complex FIR filter: controller and a chain of TAPS tap positions.
// A sample word is shifted into the delay line, its products are registered,
// and its partial sum walks the chain; no new word is taken until the result loads.
// Coefficient and clear words are taken while idle, start no sum and give no result.
// Reset (arst_n low) clears coefficients, delay line and control; tap count returns to 16.
`default_nettype none
module complex_fir_filter import cfir_pkg::*; (
	input logic clk,
	input logic arst_n,
	cfir_sample_if.sink sample_ch,
	cfir_result_if.source result_ch,
	cfir_cfg_if.sink cfg
);
	cell_ctrl_t ctrl;
	logic signed [SAMPLE_BITS-1:0] hist_real [TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_imag [TAPS];
	logic [OUT_BITS-1:0] psum_real [TAPS];
	logic [OUT_BITS-1:0] psum_imag [TAPS];
	logic signed [SAMPLE_BITS-1:0] new_real;
	logic signed [SAMPLE_BITS-1:0] new_imag;

	// Incoming sample bits taken at the delay-line width.
	assign new_real = SAMPLE_BITS'($unsigned(sample_ch.sample_real));
	assign new_imag = SAMPLE_BITS'($unsigned(sample_ch.sample_imag));

	cfir_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg(cfg),
		.chain_real(psum_real[TAPS-1]),
		.chain_imag(psum_imag[TAPS-1]),
		.ctrl(ctrl)
	);

	// Chain of tap positions; position 0 holds the newest sample.
	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		logic signed [SAMPLE_BITS-1:0] h_real_in;
		logic signed [SAMPLE_BITS-1:0] h_imag_in;
		logic [OUT_BITS-1:0] p_real_in;
		logic [OUT_BITS-1:0] p_imag_in;

		if (k == 0) begin : g_head
			assign h_real_in = new_real;
			assign h_imag_in = new_imag;
			assign p_real_in = '0;
			assign p_imag_in = '0;
		end else begin : g_body
			assign h_real_in = hist_real[k-1];
			assign h_imag_in = hist_imag[k-1];
			assign p_real_in = psum_real[k-1];
			assign p_imag_in = psum_imag[k-1];
		end

		cfir_cell_pair u_tap (
			.clk(clk),
			.arst_n(arst_n),
			.tap_pos(CELL_IDX_W'(k)),
			.ctrl(ctrl),
			.hist_real_in(h_real_in),
			.hist_imag_in(h_imag_in),
			.coef_real_in(sample_ch.coef_real),
			.coef_imag_in(sample_ch.coef_imag),
			.psum_real_in(p_real_in),
			.psum_imag_in(p_imag_in),
			.hist_real_out(hist_real[k]),
			.hist_imag_out(hist_imag[k]),
			.psum_real_out(psum_real[k]),
			.psum_imag_out(psum_imag[k])
		);
	end
endmodule
`default_nettype wire
